>>> design/svm_pkg.sv
// Shared constants, types and helpers for the stack machine executor.
package svm_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int LOCAL_COUNT = 32;
  localparam int WORD_BYTES  = 4;

  localparam int SA_W = $clog2(STACK_DEPTH);      // stack address
  localparam int SC_W = $clog2(STACK_DEPTH + 1);  // stack fill count
  localparam int LI_W = $clog2(LOCAL_COUNT);      // local index

  typedef logic [31:0]     word_t;
  typedef logic [LI_W-1:0] lidx_t;

  localparam word_t STEP_OP  = 32'(WORD_BYTES);
  localparam word_t STEP_ARG = 32'(2 * WORD_BYTES);
  localparam word_t STEP_REP = 32'(5 * WORD_BYTES);

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_DIV    = 4'd3,
    OP_EQ     = 4'd4,
    OP_NE     = 4'd5,
    OP_PUSHL  = 4'd6,
    OP_POPL   = 4'd7,
    OP_PUSHI  = 4'd8,
    OP_JMP    = 4'd9,
    OP_TJMP   = 4'd10,
    OP_END    = 4'd11,
    OP_NOP    = 4'd12,
    OP_REPEAT = 4'd13
  } opcode_t;

  typedef enum logic [1:0] {
    FLT_NONE  = 2'd0,
    FLT_UNDER = 2'd1,
    FLT_OVER  = 2'd2,
    FLT_DIV0  = 2'd3
  } fault_t;

  // raw field modulo LOCAL_COUNT; the loop makes at most eight subtractions
  function automatic lidx_t local_index(input logic [4:0] raw);
    logic [8:0] v;
    v = {4'd0, raw};
    for (int i = 0; i < 8; i++) begin
      if (v >= 9'(LOCAL_COUNT)) v = v - 9'(LOCAL_COUNT);
    end
    return v[LI_W-1:0];
  endfunction

endpackage

>>> design/svm_if.sv
// Valid/ready channel interfaces for instruction words and result words.
interface svm_in_if import svm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [3:0]         opcode;
  logic [4:0]         local_a;
  logic [4:0]         local_b;
  logic [4:0]         local_c;
  logic signed [31:0] immediate;

  modport source (output valid, opcode, local_a, local_b, local_c, immediate, input ready);
  modport sink   (input valid, opcode, local_a, local_b, local_c, immediate, output ready);
endinterface

interface svm_out_if import svm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [31:0] pc_step;
  logic               halted;
  logic signed [31:0] return_value;
  logic [1:0]         fault;

  modport source (output valid, pc_step, halted, return_value, fault, input ready);
  modport sink   (input valid, pc_step, halted, return_value, fault, output ready);
endinterface

>>> design/stack_vm_instruction_execute.sv
// Stack machine instruction executor: sequencer, shared adder, stack and locals memories.
//
//  channel  dir  handshake        word
//  -------  ---  ---------------  -----------------------------------------------
//  in_ch    in   valid/ready      opcode, local_a, local_b, local_c, immediate
//  out_ch   out  valid/ready      pc_step, halted, return_value, fault
//
//  Each word runs S_IDLE, S_DEC and S_FIN, with read, loop and repeat states between the
//  last two as the opcode needs; in_ch takes the next word in the cycle after the output
//  register loads.
//  The 33-bit adder is the one arithmetic unit; mul and div run one bit per cycle.
//  Synchronous active-low reset clears the count, halt flag and local valid bits.
//  A finished word waits in the output register while the next word is taken.
module stack_vm_instruction_execute import svm_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  svm_in_if.sink   in_ch,
  svm_out_if.source out_ch
);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_DEC   = 16'h0002,
    S_RDX   = 16'h0004,
    S_BIN   = 16'h0008,
    S_ABSX  = 16'h0010,
    S_ABSY  = 16'h0020,
    S_DIV   = 16'h0040,
    S_MUL   = 16'h0080,
    S_WRQ   = 16'h0100,
    S_PUSHL = 16'h0200,
    S_POP   = 16'h0400,
    S_RPA   = 16'h0800,
    S_RDC   = 16'h1000,
    S_RDB   = 16'h2000,
    S_RPB   = 16'h4000,
    S_FIN   = 16'h8000
  } state_t;

  // control state
  state_t            state_r, state_nxt;
  logic [SC_W-1:0]   cnt_r, cnt_nxt;
  logic              halt_r, halt_nxt;
  logic [LOCAL_COUNT-1:0] loc_vld_r, loc_vld_nxt;
  word_t             loc0_r, loc0_nxt;       // shadow of local 0 for end/halt
  logic              out_vld_r, out_vld_nxt;
  logic [4:0]        it_r, it_nxt;

  // latched instruction
  logic [3:0]        op_r, op_nxt;
  lidx_t             a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  word_t             imm_r, imm_nxt;

  // shared-unit working registers
  word_t             opd_r, opd_nxt;         // y / multiplicand / divisor / step
  word_t             wk_r, wk_nxt;           // multiplier / quotient
  logic [32:0]       acc_r, acc_nxt;         // product / remainder
  logic              neg_r, neg_nxt;

  // pending result and output register
  word_t             res_step_r, res_step_nxt;
  logic              res_halt_r, res_halt_nxt;
  word_t             res_ret_r, res_ret_nxt;
  fault_t            res_flt_r, res_flt_nxt;
  word_t             out_step_r, out_step_nxt;
  logic              out_halt_r, out_halt_nxt;
  word_t             out_ret_r, out_ret_nxt;
  fault_t            out_flt_r, out_flt_nxt;

  // memories
  word_t             stk_mem [STACK_DEPTH];
  word_t             loc_mem [LOCAL_COUNT];
  word_t             stk_q_r, loc_q_r;
  logic              loc_qv_r, loc_qz_r;

  logic              stk_we, loc_we;
  logic [SA_W-1:0]   stk_waddr, stk_raddr;
  word_t             stk_wdata, loc_wdata;
  lidx_t             loc_waddr, loc_raddr;

  // shared adder
  logic [32:0]       alu_a, alu_b, alu_s;
  logic              alu_sub;

  logic [SC_W-1:0]   cnt_m1, cnt_m2;
  logic              stk_full;
  word_t             stk_val, loc_val, q_val;

  assign alu_s    = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  assign cnt_m1   = cnt_r - SC_W'(1);
  assign cnt_m2   = cnt_r - SC_W'(2);
  assign stk_full = (cnt_r == SC_W'(STACK_DEPTH));
  assign stk_val  = stk_q_r;
  // a local never written reads as its reset value
  assign loc_val  = loc_qv_r ? loc_q_r : {31'd0, loc_qz_r};

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_vld_r;
  assign out_ch.pc_step      = out_step_r;
  assign out_ch.halted       = out_halt_r;
  assign out_ch.return_value = out_ret_r;
  assign out_ch.fault        = out_flt_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    halt_nxt     = halt_r;
    loc_vld_nxt  = loc_vld_r;
    loc0_nxt     = loc0_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    it_nxt       = it_r;
    op_nxt       = op_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    c_nxt        = c_r;
    imm_nxt      = imm_r;
    opd_nxt      = opd_r;
    wk_nxt       = wk_r;
    acc_nxt      = acc_r;
    neg_nxt      = neg_r;
    res_step_nxt = res_step_r;
    res_halt_nxt = res_halt_r;
    res_ret_nxt  = res_ret_r;
    res_flt_nxt  = res_flt_r;
    out_step_nxt = out_step_r;
    out_halt_nxt = out_halt_r;
    out_ret_nxt  = out_ret_r;
    out_flt_nxt  = out_flt_r;

    alu_a     = '0;
    alu_b     = '0;
    alu_sub   = 1'b0;
    q_val     = wk_r;
    stk_we    = 1'b0;
    stk_waddr = cnt_m2[SA_W-1:0];
    stk_wdata = alu_s[31:0];
    stk_raddr = cnt_m1[SA_W-1:0];
    loc_we    = 1'b0;
    loc_waddr = a_r;
    loc_wdata = alu_s[31:0];
    loc_raddr = a_r;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = in_ch.opcode;
          a_nxt     = local_index(in_ch.local_a);
          b_nxt     = local_index(in_ch.local_b);
          c_nxt     = local_index(in_ch.local_c);
          imm_nxt   = in_ch.immediate;
          state_nxt = S_DEC;
        end
      end

      S_DEC: begin
        // stack read of the top and local read of a are issued here
        res_step_nxt = '0;
        res_halt_nxt = 1'b0;
        res_ret_nxt  = '0;
        res_flt_nxt  = FLT_NONE;
        state_nxt    = S_FIN;
        if (halt_r) begin
          res_halt_nxt = 1'b1;
          res_ret_nxt  = loc0_r;
        end else begin
          case (op_r)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_NE: begin
              if (cnt_r < SC_W'(2)) res_flt_nxt = FLT_UNDER;
              else state_nxt = S_RDX;
            end
            OP_PUSHL: begin
              if (stk_full) res_flt_nxt = FLT_OVER;
              else state_nxt = S_PUSHL;
            end
            OP_PUSHI: begin
              if (stk_full) begin
                res_flt_nxt = FLT_OVER;
              end else begin
                stk_we       = 1'b1;
                stk_waddr    = cnt_r[SA_W-1:0];
                stk_wdata    = imm_r;
                cnt_nxt      = cnt_r + SC_W'(1);
                res_step_nxt = STEP_ARG;
              end
            end
            OP_POPL, OP_TJMP: begin
              if (cnt_r == '0) res_flt_nxt = FLT_UNDER;
              else state_nxt = S_POP;
            end
            OP_JMP: res_step_nxt = imm_r;
            OP_END: begin
              halt_nxt     = 1'b1;
              res_halt_nxt = 1'b1;
              res_ret_nxt  = loc0_r;
            end
            OP_REPEAT: state_nxt = S_RPA;
            default: res_step_nxt = STEP_OP;   // nop and unused codes
          endcase
        end
      end

      S_RDX: begin
        opd_nxt   = stk_val;                    // y = top
        stk_raddr = cnt_m2[SA_W-1:0];
        state_nxt = S_BIN;
      end

      S_BIN: begin
        alu_a   = {1'b0, stk_val};             // x
        alu_b   = {1'b0, opd_r};
        alu_sub = (op_r != OP_ADD);
        case (op_r)
          OP_MUL: begin
            wk_nxt    = opd_r;
            opd_nxt   = stk_val;
            acc_nxt   = '0;
            it_nxt    = '0;
            state_nxt = S_MUL;
          end
          OP_DIV: begin
            if (opd_r == '0) begin
              res_flt_nxt = FLT_DIV0;
              state_nxt   = S_FIN;
            end else begin
              neg_nxt   = stk_val[31] ^ opd_r[31];
              wk_nxt    = stk_val;
              state_nxt = S_ABSX;
            end
          end
          OP_EQ, OP_NE: begin
            stk_we       = 1'b1;
            stk_wdata    = {31'd0, (alu_s[31:0] == '0) ^ (op_r == OP_NE)};
            cnt_nxt      = cnt_m1;
            res_step_nxt = STEP_OP;
            state_nxt    = S_FIN;
          end
          default: begin
            stk_we       = 1'b1;
            cnt_nxt      = cnt_m1;
            res_step_nxt = STEP_OP;
            state_nxt    = S_FIN;
          end
        endcase
      end

      S_ABSX: begin
        alu_b   = {1'b0, wk_r};
        alu_sub = 1'b1;
        if (wk_r[31]) wk_nxt = alu_s[31:0];
        state_nxt = S_ABSY;
      end

      S_ABSY: begin
        alu_b   = {1'b0, opd_r};
        alu_sub = 1'b1;
        if (opd_r[31]) opd_nxt = alu_s[31:0];
        acc_nxt   = '0;
        it_nxt    = '0;
        state_nxt = S_DIV;
      end

      S_DIV: begin
        // restoring step: shift in next dividend bit, try subtract
        alu_a   = {acc_r[31:0], wk_r[31]};
        alu_b   = {1'b0, opd_r};
        alu_sub = 1'b1;
        if (!alu_s[32]) begin
          acc_nxt = alu_s;
          wk_nxt  = {wk_r[30:0], 1'b1};
        end else begin
          acc_nxt = alu_a;
          wk_nxt  = {wk_r[30:0], 1'b0};
        end
        it_nxt = it_r + 5'd1;
        if (it_r == 5'd31) state_nxt = S_WRQ;
      end

      S_MUL: begin
        alu_a = acc_r;
        alu_b = {1'b0, opd_r};
        if (wk_r[0]) acc_nxt = {1'b0, alu_s[31:0]};
        opd_nxt = {opd_r[30:0], 1'b0};
        wk_nxt  = {1'b0, wk_r[31:1]};
        it_nxt  = it_r + 5'd1;
        if (it_r == 5'd31) state_nxt = S_WRQ;
      end

      S_WRQ: begin
        alu_b   = {1'b0, wk_r};
        alu_sub = 1'b1;
        if (op_r == OP_MUL) q_val = acc_r[31:0];
        else if (neg_r)     q_val = alu_s[31:0];
        stk_we       = 1'b1;
        stk_wdata    = q_val;
        cnt_nxt      = cnt_m1;
        res_step_nxt = STEP_OP;
        state_nxt    = S_FIN;
      end

      S_PUSHL: begin
        stk_we       = 1'b1;
        stk_waddr    = cnt_r[SA_W-1:0];
        stk_wdata    = loc_val;
        cnt_nxt      = cnt_r + SC_W'(1);
        res_step_nxt = STEP_ARG;
        state_nxt    = S_FIN;
      end

      S_POP: begin
        cnt_nxt = cnt_m1;
        if (op_r == OP_POPL) begin
          loc_we       = 1'b1;
          loc_wdata    = stk_val;
          res_step_nxt = STEP_ARG;
        end else begin
          res_step_nxt = (stk_val != '0) ? imm_r : STEP_ARG;
        end
        state_nxt = S_FIN;
      end

      S_RPA: begin
        alu_a   = {1'b0, loc_val};
        alu_b   = 33'd1;
        alu_sub = 1'b1;
        if (loc_val != '0 && !loc_val[31]) begin
          loc_we    = 1'b1;                     // counter minus one
          state_nxt = S_RDC;
        end else begin
          res_step_nxt = imm_r;
          state_nxt    = S_FIN;
        end
      end

      S_RDC: begin
        loc_raddr = c_r;                        // after the decrement lands
        state_nxt = S_RDB;
      end

      S_RDB: begin
        opd_nxt   = loc_val;
        loc_raddr = b_r;
        state_nxt = S_RPB;
      end

      S_RPB: begin
        alu_a        = {1'b0, loc_val};
        alu_b        = {1'b0, opd_r};
        loc_we       = 1'b1;
        loc_waddr    = b_r;
        res_step_nxt = STEP_REP;
        state_nxt    = S_FIN;
      end

      S_FIN: begin
        if (!out_vld_r || out_ch.ready) begin
          out_vld_nxt  = 1'b1;
          out_step_nxt = res_step_r;
          out_halt_nxt = res_halt_r;
          out_ret_nxt  = res_ret_r;
          out_flt_nxt  = res_flt_r;
          state_nxt    = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (loc_we) begin
      loc_vld_nxt[loc_waddr] = 1'b1;
      if (loc_waddr == '0) loc0_nxt = loc_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      halt_r    <= 1'b0;
      loc_vld_r <= '0;
      loc0_r    <= 32'd1;
      out_vld_r <= 1'b0;
      it_r      <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      halt_r    <= halt_nxt;
      loc_vld_r <= loc_vld_nxt;
      loc0_r    <= loc0_nxt;
      out_vld_r <= out_vld_nxt;
      it_r      <= it_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    c_r        <= c_nxt;
    imm_r      <= imm_nxt;
    opd_r      <= opd_nxt;
    wk_r       <= wk_nxt;
    acc_r      <= acc_nxt;
    neg_r      <= neg_nxt;
    res_step_r <= res_step_nxt;
    res_halt_r <= res_halt_nxt;
    res_ret_r  <= res_ret_nxt;
    res_flt_r  <= res_flt_nxt;
    out_step_r <= out_step_nxt;
    out_halt_r <= out_halt_nxt;
    out_ret_r  <= out_ret_nxt;
    out_flt_r  <= out_flt_nxt;
  end

  // operand stack: one write, one registered read
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    stk_q_r <= stk_mem[stk_raddr];
  end

  // locals bank: one write, one registered read plus its valid bit
  always_ff @(posedge clk) begin
    if (loc_we) loc_mem[loc_waddr] <= loc_wdata;
    loc_q_r  <= loc_mem[loc_raddr];
    loc_qv_r <= loc_vld_r[loc_raddr];
    loc_qz_r <= (loc_raddr == '0);
  end

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= SC_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag dropped without reset");

  a_halt_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_halt_r) |-> (out_flt_r == FLT_NONE && out_step_r == '0))
    else $error("halted word carries a step or fault");

  a_iter_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRQ) |->
      (($past(state_r) == S_DIV || $past(state_r) == S_MUL) && $past(it_r) == 5'd31))
    else $error("mul/div left the loop early");

endmodule

>>> tb/stack_vm_instruction_execute_tb.sv
// Testbench for the stack machine executor: directed and random instruction streams, checked.
module stack_vm_instruction_execute_tb;
  import svm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // opcodes outside the defined set; the block treats them as nop
  localparam logic [3:0] OP_UNK_LO = 4'd14;
  localparam logic [3:0] OP_UNK_HI = 4'd15;

  localparam word_t INT_MIN     = 32'h8000_0000;
  localparam int    CYCLE_LIMIT = 1_000_000;
  // slowest word is div; give it some margin
  localparam int    SETTLE_CYCLES = 64;

  typedef struct packed {
    logic [3:0] op;
    logic [4:0] a;
    logic [4:0] b;
    logic [4:0] c;
    word_t      imm;
  } instr_t;

  typedef struct packed {
    word_t  step;
    logic   halted;
    word_t  ret;
    fault_t fault;
  } exec_result_t;

  logic clk;
  logic rst_n;
  logic rcv_ready;

  svm_in_if  in_if ();
  svm_out_if out_if ();

  assign out_if.ready = rcv_ready;

  stack_vm_instruction_execute u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source)
  );

  // Predictor state: operand stack, fill count, locals bank, halt flag.
  word_t       stk_mem  [STACK_DEPTH];
  int unsigned depth;
  word_t       locals_m [LOCAL_COUNT];
  logic        halt_seen;

  // Results still owed by the block, oldest first.
  exec_result_t due_results[$];

  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Executes one instruction on the predictor state and returns the word the
  // block must answer with. Faults leave the state as it was.
  function automatic exec_result_t step_machine(input instr_t ins);
    exec_result_t res;
    word_t        x;
    word_t        y;
    word_t        r;
    int           ai;
    int           bi;
    int           ci;
    res.step   = '0;
    res.halted = 1'b0;
    res.ret    = '0;
    res.fault  = FLT_NONE;
    ai = int'(ins.a) % LOCAL_COUNT;
    bi = int'(ins.b) % LOCAL_COUNT;
    ci = int'(ins.c) % LOCAL_COUNT;
    // once halted, everything is swallowed until reset
    if (halt_seen) begin
      res.halted = 1'b1;
      res.ret    = locals_m[0];
      return res;
    end
    case (ins.op)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_NE: begin
        if (depth < 2) begin
          res.fault = FLT_UNDER;   // underflow wins over divide by zero
        end else begin
          x = stk_mem[depth-2];
          y = stk_mem[depth-1];
          if (ins.op == OP_DIV && y == '0) begin
            res.fault = FLT_DIV0;
          end else begin
            case (ins.op)
              OP_ADD: r = x + y;
              OP_SUB: r = x - y;
              OP_MUL: r = x * y;
              // most negative over -1 wraps back to itself
              OP_DIV: r = (x == INT_MIN && y == '1) ? x : word_t'($signed(x) / $signed(y));
              OP_EQ:  r = word_t'(x == y);
              default: r = word_t'(x != y);
            endcase
            stk_mem[depth-2] = r;
            depth--;
            res.step = STEP_OP;
          end
        end
      end
      OP_PUSHL, OP_PUSHI: begin
        if (depth >= STACK_DEPTH) begin
          res.fault = FLT_OVER;
        end else begin
          stk_mem[depth] = (ins.op == OP_PUSHL) ? locals_m[ai] : ins.imm;
          depth++;
          res.step = STEP_ARG;
        end
      end
      OP_POPL, OP_TJMP: begin
        if (depth == 0) begin
          res.fault = FLT_UNDER;
        end else begin
          depth--;
          x = stk_mem[depth];
          if (ins.op == OP_POPL) begin
            locals_m[ai] = x;
            res.step = STEP_ARG;
          end else begin
            res.step = (x != '0) ? ins.imm : STEP_ARG;
          end
        end
      end
      OP_JMP: res.step = ins.imm;
      OP_END: begin
        halt_seen  = 1'b1;
        res.halted = 1'b1;
        res.ret    = locals_m[0];
      end
      OP_REPEAT: begin
        x = locals_m[ai];
        if (x != '0 && !x[31]) begin
          // decrement first: the step local is read afterwards, even if it is the counter
          locals_m[ai] = x - 1;
          locals_m[bi] = locals_m[bi] + locals_m[ci];
          res.step = STEP_REP;
        end else begin
          res.step = ins.imm;
        end
      end
      default: res.step = STEP_OP;
    endcase
    return res;
  endfunction

  // Sends one instruction word, with random idle cycles in front of it, and
  // records the expected answer once the block takes it.
  task automatic issue(input logic [3:0] op, input word_t imm = '0,
                       input logic [4:0] a = '0, input logic [4:0] b = '0,
                       input logic [4:0] c = '0);
    instr_t ins;
    ins.op  = op;
    ins.a   = a;
    ins.b   = b;
    ins.c   = c;
    ins.imm = imm;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.opcode    <= op;
    in_if.local_a   <= a;
    in_if.local_b   <= b;
    in_if.local_c   <= c;
    in_if.immediate <= imm;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    due_results.insert(due_results.size(), step_machine(ins));
  endtask

  // Wrap-around, signed division edges, divide by zero, compare ops, underflow.
  task automatic test_arith_edges();
    issue(OP_ADD);                       // empty stack
    issue(OP_PUSHI, 32'h7fff_ffff);
    issue(OP_PUSHI, 32'h0000_0001);
    issue(OP_ADD);                       // wraps to most negative
    issue(OP_PUSHI, INT_MIN);
    issue(OP_PUSHI, 32'hffff_ffff);
    issue(OP_DIV);                       // most negative / -1
    issue(OP_PUSHI, 32'h0000_0000);
    issue(OP_DIV);                       // divide by zero, state kept
    issue(OP_EQ);
    issue(OP_NE);
    issue(OP_PUSHI, 32'hffff_fffd);
    issue(OP_MUL);
    issue(OP_SUB);                       // one entry left: underflow
  endtask

  // Locals at the top index, both branches of truejmp, pop underflow, jumps, nop.
  task automatic test_locals_jumps();
    issue(OP_POPL, '0, 5'd31);
    issue(OP_PUSHL, '0, 5'd31);
    issue(OP_TJMP, 32'hffff_fff4);       // nonzero: taken
    issue(OP_PUSHI, 32'h0000_0000);
    issue(OP_TJMP, 32'h0000_0064);       // zero: falls through
    issue(OP_POPL, '0, 5'd3);            // empty stack
    issue(OP_JMP, 32'h7fff_ffff);
    issue(OP_NOP, 32'hffff_ffff);
    issue(OP_UNK_LO, INT_MIN);
  endtask

  // Counter counts down to zero, then falls out; step local equals the counter local.
  task automatic test_repeat();
    issue(OP_PUSHI, 32'h0000_0002);
    issue(OP_POPL, '0, 5'd1);
    repeat (3) issue(OP_REPEAT, 32'hffff_ffec, 5'd1, 5'd2, 5'd1);
  endtask

  function automatic logic [4:0] pick_local();
    // mostly a few hot locals so repeat counters get reused
    return $urandom_range(1) ? 5'($urandom_range(3)) : 5'($urandom_range(31));
  endfunction

  // Random program with a slight push bias and occasional push bursts that run
  // the stack into overflow.
  task automatic test_random(input int n_items, input int send_pct, input int stall_pct);
    int         burst;
    int         pick;
    logic [3:0] op;
    word_t      imm;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    burst = 0;
    for (int i = 0; i < n_items; i++) begin
      case ($urandom_range(8))
        0:       imm = INT_MIN;
        1:       imm = 32'h7fff_ffff;
        2:       imm = '1;
        3:       imm = '0;
        4, 5:    imm = word_t'($urandom_range(5));
        default: imm = $urandom();
      endcase
      if (burst == 0 && $urandom_range(49) == 0) burst = STACK_DEPTH + 2 - int'(depth);
      if (burst > 0) begin
        op = $urandom_range(1) ? OP_PUSHI : OP_PUSHL;
        burst--;
      end else begin
        pick = $urandom_range(99);
        if (pick < 40)      op = $urandom_range(1) ? OP_PUSHI : OP_PUSHL;
        else if (pick < 66) op = 4'($urandom_range(OP_NE, OP_ADD));
        else if (pick < 78) op = $urandom_range(1) ? OP_POPL : OP_TJMP;
        else if (pick < 90) op = OP_REPEAT;
        else if (pick < 94) op = OP_JMP;
        else if (pick < 97) op = OP_NOP;
        else                op = $urandom_range(1) ? OP_UNK_LO : OP_UNK_HI;
      end
      issue(op, imm, pick_local(), pick_local(), pick_local());
    end
  endtask

  // End returns local 0; everything after it is ignored.
  task automatic test_halt();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    issue(OP_PUSHI, $urandom());
    issue(OP_POPL, '0, 5'd0);
    issue(OP_END);
    issue(OP_ADD);
    issue(OP_PUSHI, 32'h1234_5678);
    issue(OP_REPEAT, 32'h0000_0010, 5'd0, 5'd1, 5'd2);
  endtask

  // Result checker: random stalls on the receive side, timeout counter.
  always @(posedge clk) begin
    exec_result_t exp;
    exec_result_t got;
    rcv_ready <= ($urandom_range(99) >= recv_stall_pct);
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else if (rst_n && out_if.valid && out_if.ready) begin
      got.step   = out_if.pc_step;
      got.halted = out_if.halted;
      got.ret    = out_if.return_value;
      got.fault  = fault_t'(out_if.fault);
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t unexpected word: step=%h halted=%b ret=%h fault=%0d",
                 $time, got.step, got.halted, got.ret, got.fault);
      end else begin
        exp = due_results.pop_front();
        if (got.step !== exp.step || got.halted !== exp.halted ||
            got.ret !== exp.ret || got.fault !== exp.fault) begin
          mismatches++;
          $display("%0t mismatch: expected step=%h halted=%b ret=%h fault=%0d",
                   $time, exp.step, exp.halted, exp.ret, exp.fault);
          $display("%0t            actual step=%h halted=%b ret=%h fault=%0d",
                   $time, got.step, got.halted, got.ret, got.fault);
        end
      end
    end
  end

  initial begin
    rcv_ready          = 1'b0;
    cycles             = 0;
    mismatches         = 0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    depth              = 0;
    halt_seen          = 1'b0;
    for (int i = 0; i < STACK_DEPTH; i++) stk_mem[i] = '0;
    for (int i = 0; i < LOCAL_COUNT; i++) locals_m[i] = '0;
    locals_m[0] = 32'd1;

    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.opcode    <= OP_NOP;
    in_if.local_a   <= '0;
    in_if.local_b   <= '0;
    in_if.local_c   <= '0;
    in_if.immediate <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_arith_edges();
    test_locals_jumps();
    test_repeat();
    test_random(415, 0, 0);
    test_random(410, 73, 0);
    test_random(410, 0, 73);
    test_random(415, 34, 34);
    test_halt();

    in_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    // nothing further may come out
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
